@@ rtl/core/scp_pkg.sv @@
package scp_pkg;

  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [23:0] SYNC_LIMIT_RESET = 24'd10485760;
  localparam logic [15:0] MAX_LEN_RESET    = 16'd65535;
  localparam logic [15:0] MIN_PACKET       = 16'd5;

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_ONE  = 8'h01;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_CUT       = 2'd1,
    ST_SYNC_FAIL = 2'd2,
    ST_EOS       = 2'd3
  } status_t;

  typedef enum logic {
    REG_SYNC_LIMIT = 1'b0,
    REG_MAX_LEN    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic [7:0] packet_code;
    status_t    status;
    logic       run_end;
  } res_t;

  function automatic res_t make_res(logic [7:0] out_byte, logic first_of_packet,
                                    logic last_of_packet, logic [7:0] packet_code,
                                    status_t status);
    res_t r;
    r.out_byte        = out_byte;
    r.first_of_packet = first_of_packet;
    r.last_of_packet  = last_of_packet;
    r.packet_code     = packet_code;
    r.status          = status;
    r.run_end         = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/scp_engine.sv @@
module scp_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   step_en,
  input  logic [7:0]                             data_byte,
  input  logic                                   end_of_stream,
  input  logic [23:0]                            sync_limit,
  input  logic [15:0]                            max_packet_length,
  output scp_pkg::res_t [scp_pkg::MAX_RESULTS-1:0] results,
  output logic [2:0]                             result_count
);

  logic        synced;
  logic        awaiting_code;
  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [15:0] packet_length;
  logic [23:0] skipped_count;
  logic [7:0]  current_code;

  logic        synced_next;
  logic        awaiting_code_next;
  logic [7:0]  held_bytes_next [3];
  logic [1:0]  held_count_next;
  logic [15:0] packet_length_next;
  logic [23:0] skipped_count_next;
  logic [7:0]  current_code_next;

  always_comb begin
    logic [15:0] maxlen;
    logic [15:0] plen_inc;
    logic [23:0] skip_inc;
    logic [15:0] pl;
    logic        cut;
    logic        fin;
    logic        stop;
    logic [2:0]  n;
    scp_pkg::res_t [scp_pkg::MAX_RESULTS-1:0] res;

    maxlen = (max_packet_length < scp_pkg::MIN_PACKET) ? scp_pkg::MIN_PACKET
                                                       : max_packet_length;
    plen_inc = packet_length + 16'd1;
    skip_inc = skipped_count + 24'd1;
    pl   = '0;
    cut  = 1'b0;
    fin  = 1'b0;
    stop = 1'b0;
    n    = '0;
    res  = '0;

    synced_next        = synced;
    awaiting_code_next = awaiting_code;
    held_bytes_next    = held_bytes;
    held_count_next    = held_count;
    packet_length_next = packet_length;
    skipped_count_next = skipped_count;
    current_code_next  = current_code;

    if (awaiting_code) begin
      current_code_next  = data_byte;
      awaiting_code_next = 1'b0;
      synced_next        = 1'b1;
      res[0] = scp_pkg::make_res(scp_pkg::START_ZERO, 1'b1, 1'b0, data_byte,
                                 scp_pkg::ST_DATA);
      res[1] = scp_pkg::make_res(scp_pkg::START_ZERO, 1'b0, 1'b0, data_byte,
                                 scp_pkg::ST_DATA);
      res[2] = scp_pkg::make_res(scp_pkg::START_ONE, 1'b0, 1'b0, data_byte,
                                 scp_pkg::ST_DATA);
      n = 3'd3;
      packet_length_next = 16'd3;
      held_bytes_next[0] = data_byte;
      held_count_next    = 2'd1;
    end else if (synced) begin
      if (held_count != 2'd3) begin
        held_bytes_next[held_count] = data_byte;
        held_count_next = held_count + 2'd1;
      end else if (held_bytes[1] == scp_pkg::START_ZERO &&
                   held_bytes[2] == scp_pkg::START_ZERO &&
                   data_byte == scp_pkg::START_ONE) begin
        res[0] = scp_pkg::make_res(held_bytes[0], 1'b0, 1'b1, current_code,
                                   scp_pkg::ST_DATA);
        n = 3'd1;
        synced_next        = 1'b0;
        awaiting_code_next = 1'b1;
        held_count_next    = 2'd0;
        packet_length_next = '0;
      end else begin
        cut = (plen_inc == maxlen);
        res[0] = scp_pkg::make_res(held_bytes[0], 1'b0, cut, current_code,
                                   cut ? scp_pkg::ST_CUT : scp_pkg::ST_DATA);
        n = 3'd1;
        held_bytes_next[0] = held_bytes[1];
        held_bytes_next[1] = held_bytes[2];
        held_bytes_next[2] = data_byte;
        packet_length_next = plen_inc;
        if (cut) begin
          synced_next        = 1'b0;
          skipped_count_next = '0;
          packet_length_next = '0;
        end
      end
    end else begin
      if (held_count != 2'd3) begin
        held_bytes_next[held_count] = data_byte;
        held_count_next = held_count + 2'd1;
      end else begin
        held_bytes_next[0] = held_bytes[1];
        held_bytes_next[1] = held_bytes[2];
        held_bytes_next[2] = data_byte;
      end
      if (held_count_next == 2'd3 &&
          held_bytes_next[0] == scp_pkg::START_ZERO &&
          held_bytes_next[1] == scp_pkg::START_ZERO &&
          held_bytes_next[2] == scp_pkg::START_ONE) begin
        awaiting_code_next = 1'b1;
        held_count_next    = 2'd0;
        skipped_count_next = '0;
      end else if (skip_inc == sync_limit) begin
        res[0] = scp_pkg::make_res(8'd0, 1'b0, 1'b0, 8'd0, scp_pkg::ST_SYNC_FAIL);
        n = 3'd1;
        skipped_count_next = '0;
      end else begin
        skipped_count_next = skip_inc;
      end
    end

    if (end_of_stream) begin
      if (synced_next) begin
        pl = packet_length_next;
        for (int i = 0; i < 3; i++) begin
          if (!stop && 2'(i) < held_count_next) begin
            fin = (2'(i + 1) == held_count_next);
            pl  = pl + 16'd1;
            cut = !fin && (pl == maxlen);
            res[n[1:0]] = scp_pkg::make_res(held_bytes_next[i], 1'b0, fin || cut,
                                            current_code_next,
                                            fin ? scp_pkg::ST_EOS :
                                            (cut ? scp_pkg::ST_CUT : scp_pkg::ST_DATA));
            n = n + 3'd1;
            if (cut) begin
              res[n[1:0]] = scp_pkg::make_res(8'd0, 1'b0, 1'b0, 8'd0, scp_pkg::ST_EOS);
              n = n + 3'd1;
              stop = 1'b1;
            end
          end
        end
      end else begin
        res[n[1:0]] = scp_pkg::make_res(8'd0, 1'b0, 1'b0, 8'd0, scp_pkg::ST_EOS);
        n = n + 3'd1;
      end
      synced_next        = 1'b0;
      awaiting_code_next = 1'b0;
      held_bytes_next[0] = '0;
      held_bytes_next[1] = '0;
      held_bytes_next[2] = '0;
      held_count_next    = '0;
      packet_length_next = '0;
      skipped_count_next = '0;
      current_code_next  = '0;
    end

    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_end = 1'b1;
    end

    results      = res;
    result_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced        <= 1'b0;
      awaiting_code <= 1'b0;
      held_bytes[0] <= '0;
      held_bytes[1] <= '0;
      held_bytes[2] <= '0;
      held_count    <= '0;
      packet_length <= '0;
      skipped_count <= '0;
      current_code  <= '0;
    end else if (step_en) begin
      synced        <= synced_next;
      awaiting_code <= awaiting_code_next;
      held_bytes    <= held_bytes_next;
      held_count    <= held_count_next;
      packet_length <= packet_length_next;
      skipped_count <= skipped_count_next;
      current_code  <= current_code_next;
    end
  end

endmodule

@@ rtl/core/scp_result_buf.sv @@
module scp_result_buf (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  scp_pkg::res_t [scp_pkg::MAX_RESULTS-1:0] results,
  input  logic [2:0]                               result_count,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output scp_pkg::res_t                            out_res,
  output logic                                     free
);

  scp_pkg::res_t [scp_pkg::MAX_RESULTS-1:0] entries;
  logic [2:0] remaining;
  logic [1:0] rd_ptr;

  assign out_valid = (remaining != 3'd0);
  assign out_res   = entries[rd_ptr];
  // free when empty or once the last held result leaves this cycle
  assign free      = (remaining == 3'd0) || (remaining == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      rd_ptr    <= '0;
    end else if (load) begin
      remaining <= result_count;
      rd_ptr    <= '0;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - 3'd1;
      rd_ptr    <= rd_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= results;
    end
  end

endmodule

@@ rtl/core/start_code_packetizer_unit.sv @@
// Start-code packetizer: takes one stream byte per transfer on s_*, finds 00 00 01 xx
// packets and gives them out byte by byte on m_*, start code and code byte first, with
// packet boundaries, cut and sync-failure markers. One result leaves per cycle while
// m_tready is high; an input byte giving one result (the usual payload case) is then taken
// every cycle, while the byte after a start code gives three results and an end-of-stream
// byte up to four, so the input is held while the four-entry result buffer drains. Config
// writes are taken at any time but must only be made while the block is idle.
module start_code_packetizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte, packet_code, run_end, zero fill
  output logic        m_tlast,   // last_of_packet
  output logic [2:0]  m_tuser,   // first_of_packet, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_eos;
  logic        step_en;
  logic        buf_free;
  logic [23:0] sync_limit;
  logic [15:0] max_packet_length;

  scp_pkg::res_t [scp_pkg::MAX_RESULTS-1:0] results;
  logic [2:0]    result_count;
  scp_pkg::res_t out_res;

  assign step_en   = in_valid && buf_free;
  assign s_tready  = !in_valid || step_en;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_limit        <= scp_pkg::SYNC_LIMIT_RESET;
      max_packet_length <= scp_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (scp_pkg::reg_index_t'(cfg_index))
        scp_pkg::REG_SYNC_LIMIT: sync_limit        <= cfg_data;
        scp_pkg::REG_MAX_LEN:    max_packet_length <= cfg_data[15:0];
        default:                 sync_limit        <= sync_limit;
      endcase
    end
  end

  scp_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .step_en           (step_en),
    .data_byte         (in_byte),
    .end_of_stream     (in_eos),
    .sync_limit        (sync_limit),
    .max_packet_length (max_packet_length),
    .results           (results),
    .result_count      (result_count)
  );

  scp_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (step_en),
    .results      (results),
    .result_count (result_count),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_res      (out_res),
    .free         (buf_free)
  );

  assign m_tdata = {7'd0, out_res.run_end, out_res.packet_code, out_res.out_byte};
  assign m_tlast = out_res.last_of_packet;
  assign m_tuser = {out_res.status, out_res.first_of_packet};

  a_first_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0 && !m_tlast &&
                               m_tuser[2:1] == scp_pkg::ST_DATA)
    else $error("first byte of packet is not a plain zero");

  a_cut_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == scp_pkg::ST_CUT |-> m_tlast)
    else $error("cut result without last_of_packet");

  a_sync_fail_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == scp_pkg::ST_SYNC_FAIL |->
      m_tdata[15:0] == 16'd0 && !m_tlast && !m_tuser[0])
    else $error("sync failure marker carries packet data");

  a_step_needs_room: assert property (@(posedge clk) disable iff (rst)
    step_en && result_count != 3'd0 |=> m_tvalid)
    else $error("results of a step were not presented");

endmodule
